// File: hdl/two_weight_deque_shortest_path_macros.svh
// assertion macros used by the checker file
`ifndef TWO_WEIGHT_DEQUE_SHORTEST_PATH_MACROS_SVH
`define TWO_WEIGHT_DEQUE_SHORTEST_PATH_MACROS_SVH

// same-cycle implication, checked outside reset
`define TWDSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: lbl");

// next-cycle implication, checked outside reset
`define TWDSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`endif

// File: hdl/twdsp_pkg.sv
// ----------------------------------------------------------------------------
// twdsp_pkg
// shared widths, defaults and register codes of the 0-1 deque search block
// ----------------------------------------------------------------------------
`default_nettype none
package twdsp_pkg;
  localparam int VERTEX_W = 10;
  localparam int COST_W = 16;
  localparam int DIST_W = 31;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_EDGES = 4096;
  localparam int DEF_DEQUE_DEPTH = 4096;

  localparam logic [CFG_INDEX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COST_FIRST = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COST_SECOND = 2'd3;

  // infinite distance: bit 31 set
  localparam logic [31:0] DIST_INF = 32'h8000_0000;

  typedef struct packed {
    logic add_front;
    logic add_back;
    logic pop;
  } deque_cmd_t;
endpackage
`default_nettype wire

// File: hdl/twdsp_ram.sv
// ----------------------------------------------------------------------------
// twdsp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module twdsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/twdsp_deque.sv
// ----------------------------------------------------------------------------
// twdsp_deque
// circular work deque over one ram: push at either end, pop from the front
// ----------------------------------------------------------------------------
`default_nettype none
module twdsp_deque import twdsp_pkg::*; #(
  parameter int DEPTH = DEF_DEQUE_DEPTH,
  parameter int DATA_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire deque_cmd_t        cmd,
  input  wire logic [DATA_W-1:0] push_data,
  output logic      [DATA_W-1:0] rd_data,
  output logic                   empty,
  output logic                   full
);
  localparam int DW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [DW-1:0] front, front_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW:0]   back_sum;
  logic [DW-1:0] back_addr, front_dec, front_inc;
  logic [DW-1:0] waddr;
  logic          we;

  assign empty = (fill == '0);
  assign full = (fill == FW'(DEPTH));

  always_comb begin
    back_sum = {1'b0, FW'(front)} + {1'b0, fill};
    if (back_sum >= (FW + 1)'(DEPTH)) begin
      back_sum = back_sum - (FW + 1)'(DEPTH);
    end
    back_addr = back_sum[DW-1:0];
    front_dec = (front == '0) ? DW'(DEPTH - 1) : front - 1'b1;
    front_inc = (front == DW'(DEPTH - 1)) ? '0 : front + 1'b1;
  end

  always_comb begin
    front_next = front;
    fill_next = fill;
    we = 1'b0;
    waddr = back_addr;
    if (clear) begin
      front_next = '0;
      fill_next = '0;
    end else if (cmd.pop && !empty) begin
      front_next = front_inc;
      fill_next = fill - 1'b1;
    end else if (cmd.add_front && !full) begin
      front_next = front_dec;
      fill_next = fill + 1'b1;
      we = 1'b1;
      waddr = front_dec;
    end else if (cmd.add_back && !full) begin
      fill_next = fill + 1'b1;
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      fill <= '0;
    end else begin
      front <= front_next;
      fill <= fill_next;
    end
  end

  twdsp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(push_data),
    .re   (cmd.pop),
    .raddr(front),
    .rdata(rd_data)
  );
endmodule
`default_nettype wire

// File: hdl/two_weight_deque_shortest_path.sv
// ----------------------------------------------------------------------------
// two_weight_deque_shortest_path
// loads directed edges, then runs a 0-1 deque search and reports a distance
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one edge per item; the item with
//   last_edge set is stored and then starts the search from start_vertex.
//   output channel (out_valid/out_ready) gives one item per search: distance,
//   reachable and overflow (an edge or deque push was dropped).
//   configuration is written through cfg_we/cfg_index/cfg_data while idle.
// timing:
//   an edge is stored by a read of the vertex head/tail entry, then a write.
//   the search steps through S_POP, S_VRD and S_VCHK per deque pop and
//   through S_ERD, S_EW and S_RELAX per edge walked.
//   the result holds until taken; a stalled receiver stalls the block.
// reset and clear:
//   after reset, and after each result is taken, a clearing pass walks every
//   entry of the vertex and distance memories, with in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none
module two_weight_deque_shortest_path import twdsp_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int DEQUE_DEPTH = DEF_DEQUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VERTEX_W-1:0]    from_vertex,
  input  wire logic [VERTEX_W-1:0]    to_vertex,
  input  wire logic [COST_W-1:0]      edge_weight,
  input  wire logic                   last_edge,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [DIST_W-1:0]      distance,
  output logic                        reachable,
  output logic                        overflow
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int LW = $clog2(MAX_EDGES + 1);
  localparam logic [LW-1:0] LIST_END = LW'(MAX_EDGES);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_LWR   = 13'b0000000000100,
    S_INIT  = 13'b0000000001000,
    S_POP   = 13'b0000000010000,
    S_VRD   = 13'b0000000100000,
    S_VCHK  = 13'b0000001000000,
    S_ERD   = 13'b0000010000000,
    S_EW    = 13'b0000100000000,
    S_RELAX = 13'b0001000000000,
    S_RRD   = 13'b0010000000000,
    S_RES   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [VERTEX_W-1:0] start_vertex, target_vertex;
  logic [COST_W-1:0]   cost_first, cost_second, low_cost;

  // latched edge
  logic [VW-1:0]     ld_from, ld_to;
  logic [COST_W-1:0] ld_weight;
  logic              ld_last, ld_ok;

  logic [LW-1:0] edges_loaded;
  logic          overflow_seen;
  logic [VW-1:0] clr_addr;

  // search registers
  logic [EW-1:0]     cur_edge, cur_link;
  logic [LW-1:0]     cur_tail;
  logic [31:0]       dist_v;
  logic [VW-1:0]     cur_dest;
  logic [COST_W-1:0] cur_cost;

  logic [31:0] from_ext, to_ext, start_ext, target_ext;
  logic        from_ok, to_ok, start_ok, target_ok, edges_full;
  logic        accept;

  // memory ports
  logic                vert_we, vert_re;
  logic [VW-1:0]       vert_waddr, vert_raddr;
  logic [2*LW-1:0]     vert_wdata, vert_rdata;
  logic [LW-1:0]       head_rd, tail_rd;
  logic                dist_we, dist_re;
  logic [VW-1:0]       dist_waddr, dist_raddr;
  logic [31:0]         dist_wdata, dist_rdata;
  logic                edge_we, edge_re, link_we;
  logic [EW-1:0]       link_waddr;
  logic [VW+COST_W-1:0] edge_rdata;
  logic [EW-1:0]       link_rdata;

  deque_cmd_t    dq_cmd;
  logic [VW-1:0] dq_wdata, dq_rdata;
  logic          dq_empty, dq_full, dq_clear;

  logic [32:0] cand;
  logic        improve;
  logic [31:0] res_dist;

  assign low_cost = (cost_first < cost_second) ? cost_first : cost_second;
  assign from_ext = 32'(from_vertex);
  assign to_ext = 32'(to_vertex);
  assign start_ext = 32'(start_vertex);
  assign target_ext = 32'(target_vertex);
  assign from_ok = from_ext < 32'(MAX_VERTICES);
  assign to_ok = to_ext < 32'(MAX_VERTICES);
  assign start_ok = start_ext < 32'(MAX_VERTICES);
  assign target_ok = target_ext < 32'(MAX_VERTICES);
  assign edges_full = (edges_loaded == LIST_END);

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept = in_valid && in_ready;

  assign head_rd = vert_rdata[2*LW-1:LW];
  assign tail_rd = vert_rdata[LW-1:0];
  assign cand = {1'b0, dist_v} + 33'(cur_cost);
  assign improve = {1'b0, dist_rdata} > cand;
  assign res_dist = target_ok ? dist_rdata : DIST_INF;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_vertex <= '0;
      target_vertex <= '0;
      cost_first <= '0;
      cost_second <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:       start_vertex <= cfg_data[VERTEX_W-1:0];
        CFG_TARGET:      target_vertex <= cfg_data[VERTEX_W-1:0];
        CFG_COST_FIRST:  cost_first <= cfg_data[COST_W-1:0];
        CFG_COST_SECOND: cost_second <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // memory port selection per state
  always_comb begin
    vert_we = 1'b0;
    vert_waddr = ld_from;
    vert_wdata = {LIST_END, LIST_END};
    vert_re = 1'b0;
    vert_raddr = from_ext[VW-1:0];
    dist_we = 1'b0;
    dist_waddr = clr_addr;
    dist_wdata = DIST_INF;
    dist_re = 1'b0;
    dist_raddr = dq_rdata;
    edge_we = 1'b0;
    edge_re = 1'b0;
    link_we = 1'b0;
    link_waddr = tail_rd[EW-1:0];
    dq_cmd = '0;
    dq_wdata = start_ext[VW-1:0];
    dq_clear = 1'b0;
    unique case (state)
      S_CLEAR: begin
        vert_we = 1'b1;
        vert_waddr = clr_addr;
        dist_we = 1'b1;
      end
      S_IDLE: begin
        vert_re = accept;
      end
      S_LWR: begin
        if (ld_ok) begin
          edge_we = 1'b1;
          vert_we = 1'b1;
          if (head_rd == LIST_END) begin
            vert_wdata = {edges_loaded, edges_loaded};
          end else begin
            vert_wdata = {head_rd, edges_loaded};
            link_we = 1'b1;
          end
        end
      end
      S_INIT: begin
        if (start_ok) begin
          dist_we = 1'b1;
          dist_waddr = start_ext[VW-1:0];
          dist_wdata = '0;
          dq_cmd.add_back = 1'b1;
        end
      end
      S_POP: begin
        dq_cmd.pop = 1'b1;
      end
      S_VRD: begin
        vert_re = 1'b1;
        vert_raddr = dq_rdata;
        dist_re = 1'b1;
      end
      S_VCHK: ;
      S_ERD: begin
        edge_re = 1'b1;
      end
      S_EW: begin
        dist_re = 1'b1;
        dist_raddr = edge_rdata[VW+COST_W-1:COST_W];
      end
      S_RELAX: begin
        if (improve) begin
          dist_we = 1'b1;
          dist_waddr = cur_dest;
          dist_wdata = cand[31:0];
          dq_wdata = cur_dest;
          if (cur_cost == low_cost) begin
            dq_cmd.add_front = 1'b1;
          end else begin
            dq_cmd.add_back = 1'b1;
          end
        end
      end
      S_RRD: begin
        dist_re = 1'b1;
        dist_raddr = target_ext[VW-1:0];
      end
      S_RES: ;
      S_OUT: begin
        dq_clear = out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == VW'(MAX_VERTICES - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_LWR;
      S_LWR:   state_next = ld_last ? S_INIT : S_IDLE;
      S_INIT:  state_next = start_ok ? S_POP : S_RRD;
      S_POP:   state_next = dq_empty ? S_RRD : S_VRD;
      S_VRD:   state_next = S_VCHK;
      S_VCHK:  state_next = (head_rd == LIST_END) ? S_POP : S_ERD;
      S_ERD:   state_next = S_EW;
      S_EW:    state_next = S_RELAX;
      S_RELAX: state_next = (LW'(cur_edge) == cur_tail) ? S_POP : S_ERD;
      S_RRD:   state_next = S_RES;
      S_RES:   state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_CLEAR;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      edges_loaded <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (state == S_LWR) begin
        if (ld_ok) begin
          edges_loaded <= edges_loaded + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      // a push into a full deque is dropped
      if (state == S_RELAX && improve && dq_full) begin
        overflow_seen <= 1'b1;
      end
      if (state == S_OUT && out_ready) begin
        edges_loaded <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_from <= from_ext[VW-1:0];
      ld_to <= to_ext[VW-1:0];
      ld_weight <= edge_weight;
      ld_last <= last_edge;
      ld_ok <= from_ok && to_ok && !edges_full;
    end
    if (state == S_VCHK) begin
      cur_edge <= head_rd[EW-1:0];
      cur_tail <= tail_rd;
      dist_v <= dist_rdata;
    end
    if (state == S_EW) begin
      cur_dest <= edge_rdata[VW+COST_W-1:COST_W];
      cur_cost <= edge_rdata[COST_W-1:0];
      cur_link <= link_rdata;
    end
    if (state == S_RELAX) begin
      cur_edge <= cur_link;
    end
    if (state == S_RES) begin
      reachable <= ~res_dist[31];
      distance <= res_dist[31] ? '0 : res_dist[DIST_W-1:0];
      overflow <= overflow_seen;
    end
  end

  // vertex entry holds the list head and tail edge indexes
  twdsp_ram #(.WIDTH(2 * LW), .DEPTH(MAX_VERTICES)) u_vert_ram (
    .clk(clk), .we(vert_we), .waddr(vert_waddr), .wdata(vert_wdata),
    .re(vert_re), .raddr(vert_raddr), .rdata(vert_rdata)
  );

  twdsp_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(dist_re), .raddr(dist_raddr), .rdata(dist_rdata)
  );

  twdsp_ram #(.WIDTH(VW + COST_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edges_loaded[EW-1:0]),
    .wdata({ld_to, ld_weight}), .re(edge_re), .raddr(cur_edge),
    .rdata(edge_rdata)
  );

  // links are only followed up to the tail, so the last edge needs no end mark
  twdsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(edges_loaded[EW-1:0]),
    .re(edge_re), .raddr(cur_edge), .rdata(link_rdata)
  );

  twdsp_deque #(.DEPTH(DEQUE_DEPTH), .DATA_W(VW)) u_deque (
    .clk      (clk),
    .rst      (rst),
    .clear    (dq_clear),
    .cmd      (dq_cmd),
    .push_data(dq_wdata),
    .rd_data  (dq_rdata),
    .empty    (dq_empty),
    .full     (dq_full)
  );
endmodule
`default_nettype wire

// File: hdl/twdsp_checker.sv
// ----------------------------------------------------------------------------
// twdsp_checker
// port-level checks of the deque search block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_weight_deque_shortest_path_macros.svh"
module twdsp_checker import twdsp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DIST_W-1:0] distance,
  input wire logic              reachable,
  input wire logic              overflow
);
  // one edge in flight: no new item while a result waits
  `TWDSP_ASSERT_NOW(a_no_accept_with_result, out_valid, !in_ready)
  // in_ready is low after each accepted edge item, while the item is stored
  `TWDSP_ASSERT_NEXT(a_edge_two_cycles, in_valid && in_ready, !in_ready)
  // unreachable target reports a zero distance
  `TWDSP_ASSERT_NOW(a_unreached_zero, out_valid && !reachable, distance == '0)
  // a result stays put while stalled
  `TWDSP_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                     out_valid && $stable(distance) && $stable(reachable) && $stable(overflow))
endmodule

bind two_weight_deque_shortest_path twdsp_checker u_twdsp_checker (.*);
`default_nettype wire

// File: bench/tb_two_weight_deque_shortest_path.sv
// ----------------------------------------------------------------------------
// tb_two_weight_deque_shortest_path
// self-checking bench: edge graphs are streamed in, a local 0-1 deque search
// predicts each distance item, and the monitor compares every output field
// ----------------------------------------------------------------------------
`default_nettype none
module tb_two_weight_deque_shortest_path import twdsp_pkg::*;;

  localparam int N_VERT = DEF_MAX_VERTICES;
  localparam int N_EDGE = DEF_MAX_EDGES;
  localparam int N_DEQ = DEF_DEQUE_DEPTH;
  localparam int CLEAR_WAIT = N_VERT + 200;
  localparam int LONG_HOLD = 3000;

  typedef struct packed {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    logic [COST_W-1:0] weight;
    logic last;
  } edge_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_len;
    logic reach;
    logic ovf;
  } path_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VERTEX_W-1:0] from_vertex = '0;
  logic [VERTEX_W-1:0] to_vertex = '0;
  logic [COST_W-1:0] edge_weight = '0;
  logic last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] distance;
  logic reachable;
  logic overflow;

  two_weight_deque_shortest_path uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .from_vertex(from_vertex), .to_vertex(to_vertex),
    .edge_weight(edge_weight), .last_edge(last_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .distance(distance), .reachable(reachable), .overflow(overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- local search model ----------------
  logic [VERTEX_W-1:0] start_reg = '0, target_reg = '0;
  logic [COST_W-1:0] cost_a = '0, cost_b = '0;

  int unsigned e_dst [N_EDGE];
  int unsigned e_cost [N_EDGE];
  int unsigned e_link [N_EDGE];
  int unsigned v_head [N_VERT];
  int unsigned v_tail [N_VERT];
  longint unsigned v_dist [N_VERT];
  int unsigned deq [N_DEQ];
  int unsigned deq_front, deq_fill, n_edges;
  bit ovf_flag;

  path_result_t expected_paths[$];
  edge_item_t pending_edges[$];

  int mismatches = 0;
  int results_seen = 0;
  int edges_sent = 0;
  int graphs_sent = 0;
  bit hold_off_req = 1'b0;
  bit sender_pause = 1'b0;

  function automatic void clear_graph();
    for (int v = 0; v < N_VERT; v++) begin
      v_head[v] = N_EDGE;
      v_tail[v] = N_EDGE;
      v_dist[v] = 64'h8000_0000;
    end
    deq_front = 0;
    deq_fill = 0;
    n_edges = 0;
    ovf_flag = 1'b0;
  endfunction

  function automatic void enqueue_vertex(int unsigned v, bit at_front);
    if (deq_fill >= N_DEQ) begin
      ovf_flag = 1'b1;
    end else if (at_front) begin
      deq_front = (deq_front + N_DEQ - 1) % N_DEQ;
      deq[deq_front] = v;
      deq_fill++;
    end else begin
      deq[(deq_front + deq_fill) % N_DEQ] = v;
      deq_fill++;
    end
  endfunction

  function automatic void absorb_edge(edge_item_t it);
    int unsigned low_cost, v, e, dn;
    longint unsigned cand, d;
    path_result_t r;
    if (n_edges >= N_EDGE) begin
      ovf_flag = 1'b1;
    end else begin
      e = n_edges++;
      e_dst[e] = it.dst;
      e_cost[e] = it.weight;
      e_link[e] = N_EDGE;
      if (v_head[it.src] == N_EDGE) v_head[it.src] = e;
      else e_link[v_tail[it.src]] = e;
      v_tail[it.src] = e;
    end
    if (!it.last) return;
    low_cost = (cost_a < cost_b) ? cost_a : cost_b;
    v_dist[start_reg] = 0;
    enqueue_vertex(start_reg, 1'b0);
    while (deq_fill > 0) begin
      v = deq[deq_front];
      deq_front = (deq_front + 1) % N_DEQ;
      deq_fill--;
      e = v_head[v];
      while (e < N_EDGE) begin
        dn = e_dst[e];
        cand = v_dist[v] + e_cost[e];
        if (v_dist[dn] > cand) begin
          v_dist[dn] = cand;
          enqueue_vertex(dn, e_cost[e] == low_cost);
        end
        e = e_link[e];
      end
    end
    d = v_dist[target_reg];
    r.reach = d < 64'h8000_0000;
    r.path_len = r.reach ? d[DIST_W-1:0] : '0;
    r.ovf = ovf_flag;
    expected_paths.insert(expected_paths.size(), r);
    clear_graph();
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  // ---------------- driver ----------------
  int drv_gap = 0;
  edge_item_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && in_ready) absorb_edge(drv_item);
      if (in_valid && !in_ready) begin
        // hold the item until it is taken
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (pending_edges.size() > 0 && !sender_pause) begin
        drv_item = pending_edges[0];
        pending_edges.delete(0);
        from_vertex <= drv_item.src;
        to_vertex <= drv_item.dst;
        edge_weight <= drv_item.weight;
        last_edge <= drv_item.last;
        in_valid <= 1'b1;
        drv_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int mon_stall = 0;
  bit hold_done = 1'b0;
  path_result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{distance, reachable, overflow};
        results_seen++;
        if (expected_paths.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: len=%0d reach=%0b ovf=%0b",
                                         got.path_len, got.reach, got.ovf);
        end else begin
          want = expected_paths[0];
          expected_paths.delete(0);
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: len exp %0d got %0d, reach exp %0b got %0b,",
                        " ovf exp %0b got %0b"},
                       want.path_len, got.path_len, want.reach, got.reach,
                       want.ovf, got.ovf);
          end
        end
      end
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        mon_stall = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (mon_stall > 0) begin
        mon_stall--;
        out_ready <= 1'b0;
      end else begin
        mon_stall = pick_gap();
        out_ready <= (mon_stall == 0);
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [VERTEX_W-1:0] pick_vertex(int span);
    int p;
    p = $urandom_range(99);
    if (p < 20) return start_reg;
    if (p < 35) return target_reg;
    if (p < 90) return start_reg ^ VERTEX_W'($urandom_range(span - 1));
    return VERTEX_W'($urandom());
  endfunction

  function automatic logic [COST_W-1:0] pick_weight();
    int p;
    p = $urandom_range(99);
    if (p < 40) return cost_a;
    if (p < 75) return cost_b;
    if (p < 90) return COST_W'($urandom_range(20));
    return COST_W'($urandom());
  endfunction

  task automatic add_edge(int s, int d, int w, bit last);
    edge_item_t it;
    it = '{VERTEX_W'(s), VERTEX_W'(d), COST_W'(w), last};
    pending_edges.insert(pending_edges.size(), it);
    edges_sent++;
    if (last) graphs_sent++;
  endtask

  task automatic add_graph(int n_items, int span);
    for (int i = 0; i < n_items; i++)
      add_edge(pick_vertex(span), pick_vertex(span), pick_weight(), i == n_items - 1);
  endtask

  task automatic wait_idle();
    while (pending_edges.size() > 0 || in_valid || expected_paths.size() > 0)
      @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_START: start_reg = val[VERTEX_W-1:0];
      CFG_TARGET: target_reg = val[VERTEX_W-1:0];
      CFG_COST_FIRST: cost_a = val;
      default: cost_b = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int s, int t, int ca, int cb);
    wait_idle();
    write_reg(CFG_START, CFG_DATA_W'(s));
    write_reg(CFG_TARGET, CFG_DATA_W'(t));
    write_reg(CFG_COST_FIRST, CFG_DATA_W'(ca));
    write_reg(CFG_COST_SECOND, CFG_DATA_W'(cb));
  endtask

  initial begin
    int n;
    clear_graph();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: chain 0->1->2->3 with a dearer direct edge 0->3, extremes of fields
    set_config(0, 3, 0, 1);
    add_edge(0, 1, 1, 0);
    add_edge(1, 2, 0, 0);
    add_edge(2, 3, 1, 0);
    add_edge(0, 3, 5, 0);
    add_edge(3, 3, 0, 0);
    add_edge(1023, 0, 65535, 0);
    add_edge(0, 1023, 65535, 1);
    // target never reached
    add_edge(1, 2, 1, 0);
    add_edge(3, 0, 1, 1);
    // single edge, a self loop on the start vertex
    add_edge(0, 0, 0, 1);
    set_config(1023, 0, 65535, 0);
    add_edge(1023, 512, 0, 0);
    add_edge(512, 0, 65535, 0);
    add_edge(1023, 0, 65535, 0);
    add_edge(512, 1023, 0, 1);
    set_config(16'hfc00 | 341, 16'hfc00 | 682, 65535, 65535);
    add_edge(341, 682, 65535, 0);
    add_edge(682, 341, 1, 0);
    add_edge(341, 100, 2, 0);
    add_edge(100, 682, 3, 1);
    add_edge(5, 6, 0, 1);

    // receiver holds off while the sender keeps going
    set_config(7, 9, 0, 0);
    hold_off_req = 1'b1;
    for (int g = 0; g < 8; g++) add_graph($urandom_range(6, 1), 8);

    // random phases
    n = 0;
    while (n < 1560) begin
      case ($urandom_range(3))
        0: set_config($urandom(), $urandom(), 0, $urandom_range(3));
        1: set_config($urandom(), $urandom(), 65535, $urandom());
        2: set_config($urandom(), $urandom(), $urandom_range(10), $urandom_range(10));
        default: set_config($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      for (int g = 0; g < 12; g++) begin
        int sz;
        sz = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(16, 1);
        add_graph(sz, ($urandom_range(1)) ? 8 : 32);
        n += sz;
        // occasionally wait for every result before offering more
        if ($urandom_range(9) == 0) begin
          sender_pause = 1'b1;
          while (expected_paths.size() > 0 || pending_edges.size() > 0 || in_valid)
            begin
              sender_pause = pending_edges.size() > 0 ? 1'b0 : 1'b1;
              @(posedge clk);
            end
          sender_pause = 1'b0;
        end
      end
    end

    wait_idle();
    $display("ran %0d edges in %0d graphs, %0d distance items checked",
             edges_sent, graphs_sent, results_seen);
    $display("covered both cost orders, cost extremes, wide config writes and output stalls");
    if (mismatches == 0 && expected_paths.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
